>>> design/rlpe_pkg.sv
// Shared types, constants and helper functions of the RLP prefix encoder.
package rlpe_pkg;

   localparam int SHORT_LIMIT = 56;
   localparam logic [7:0] STRING_OFFSET = 8'h80;
   localparam logic [7:0] LIST_OFFSET = 8'hC0;
   localparam logic [7:0] LONG_BASE = 8'd55;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   localparam int WORD_BYTES = 8;
   localparam int NBYTE_W = $clog2(WORD_BYTES + 1);
   localparam int SHIFT_W = $clog2(WORD_BYTES);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_INT  = 2'd0,
      MODE_STR  = 2'd1,
      MODE_LIST = 2'd2,
      MODE_BYTE = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [63:0] value;
      logic [63:0] length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   // One queued transfer run: header byte, then nbody body bytes taken
   // from the top of body.
   typedef struct packed {
      logic [7:0]         head;
      logic [63:0]        body;
      logic [NBYTE_W-1:0] nbody;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Significant byte count of v (0 when v is zero).
   function automatic logic [NBYTE_W-1:0] be_len(logic [63:0] v);
      logic [NBYTE_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_BYTES; i++) begin
         if (v[i*8 +: 8] != 8'd0) begin
            n = NBYTE_W'(i + 1);
         end
      end
      return n;
   endfunction

   // Move the n significant bytes of v to the top of the word.
   function automatic logic [63:0] be_align(logic [63:0] v, logic [NBYTE_W-1:0] n);
      logic [SHIFT_W-1:0] sh;
      sh = SHIFT_W'(NBYTE_W'(WORD_BYTES) - n);
      return v << {sh, 3'b000};
   endfunction

endpackage

>>> design/rlp_prefix_encoder_top.sv
// Top level of the RLP prefix encoder.
//
// Request channel (req_valid/req_ready/req_data) takes one item per transfer:
// an integer, a string or list header, or one payload byte. The response
// channel (rsp_valid/rsp_ready/rsp_data) delivers the encoding one byte per
// transfer, with last_byte set on the final byte of each item's run. A string
// header of length one whose byte is below 0x80 produces no bytes at all.
// The front end classifies an item in the cycle it is accepted and writes a
// job (header byte, aligned body bytes, body count) into a four-entry queue.
// The back end pops a job and emits its header and 0..8 body bytes through a
// registered output stage, one byte per cycle while rsp_ready does not stall it.
// A request's first byte passes through the queue, the run registers and the output register.
// Throughput: one output byte per cycle unless rsp_ready stalls, set by the single
// output register; single-byte items (payload bytes, small integers, short headers)
// sustain one item per cycle, and an item with n body bytes emits 1 + n bytes.
// req_ready drops only when the queue is full.
// Reset clears the queue and the output register; no item is in flight after.
// A stalled rsp_ready holds the current byte and backs up into the queue.
module rlp_prefix_encoder_top
   import rlpe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   qstat_type q_stat;
   logic      push, pop;
   job_type   wr_job, rd_job;

   rlpe_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .job       (wr_job)
   );

   rlpe_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_job (wr_job),
      .pop    (pop),
      .rd_job (rd_job),
      .q_stat (q_stat)
   );

   rlpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rd_job    (rd_job),
      .q_stat    (q_stat),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/rlpe_front.sv
// Front end: accepts request transfers and turns each into a queued byte run.
module rlpe_front
   import rlpe_pkg::*;
(
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   input  qstat_type q_stat,
   output logic      push,
   output job_type   job
);

   logic [NBYTE_W-1:0] n_value;
   logic [NBYTE_W-1:0] n_length;
   logic [7:0]         offset;
   logic               drop;

   always_comb begin
      n_value = be_len(req_data.value);
      n_length = be_len(req_data.length);
      offset = (req_data.mode == MODE_LIST) ? LIST_OFFSET : STRING_OFFSET;
      drop = 1'b0;
      job.head = req_data.data_byte;
      job.body = '0;
      job.nbody = '0;
      unique case (req_data.mode)
         MODE_INT: begin
            if (req_data.value == 64'd0) begin
               job.head = STRING_OFFSET;
            end else if (req_data.value < 64'(STRING_OFFSET)) begin
               job.head = req_data.value[7:0];
            end else begin
               job.head = STRING_OFFSET + 8'(n_value);
               job.body = be_align(req_data.value, n_value);
               job.nbody = n_value;
            end
         end
         MODE_STR, MODE_LIST: begin
            if (req_data.mode == MODE_STR && req_data.length == 64'd1 &&
                req_data.data_byte < STRING_OFFSET) begin
               drop = 1'b1;
            end
            if (req_data.length < 64'(SHORT_LIMIT)) begin
               job.head = (offset + req_data.length[7:0]) & BYTE_MASK;
            end else begin
               job.head = offset + LONG_BASE + 8'(n_length);
               job.body = be_align(req_data.length, n_length);
               job.nbody = n_length;
            end
         end
         MODE_BYTE: begin
            job.head = req_data.data_byte;
         end
         default: begin
            job.head = req_data.data_byte;
         end
      endcase
      req_ready = !q_stat.full;
      push = req_valid && req_ready && !drop;
   end

endmodule

>>> design/rlpe_queue.sv
// Short job queue between the front end and the byte emitter.
module rlpe_queue
   import rlpe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   wr_job,
   input  logic      pop,
   output job_type   rd_job,
   output qstat_type q_stat
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_push, do_pop;

   always_comb begin
      q_stat.full = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
      q_stat.empty = (cnt_ff == '0);
      do_push = push && !q_stat.full;
      do_pop = pop && !q_stat.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
      rd_job = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == QCNT_W'(QUEUE_DEPTH)) |-> rd_ptr_ff == wr_ptr_ff)
      else $error("queue pointers disagree with count");

endmodule

>>> design/rlpe_back.sv
// Back end: emits each queued run one byte per transfer through an output register.
module rlpe_back
   import rlpe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  job_type   rd_job,
   input  qstat_type q_stat,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic               busy_ff, busy_in;
   logic               hdr_ff, hdr_in;
   logic [7:0]         head_ff, head_in;
   logic [63:0]        body_ff, body_in;
   logic [NBYTE_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               load_out, advance, cur_last;
   logic [7:0]         cur_byte;

   always_comb begin
      load_out = !rsp_valid_ff || rsp_ready;
      cur_byte = hdr_ff ? head_ff : body_ff[63:56];
      cur_last = hdr_ff ? (cnt_ff == '0) : (cnt_ff == NBYTE_W'(1));
      advance = busy_ff && load_out;
      pop = !q_stat.empty && (!busy_ff || (advance && cur_last));

      busy_in = busy_ff;
      hdr_in = hdr_ff;
      head_in = head_ff;
      body_in = body_ff;
      cnt_in = cnt_ff;
      if (advance) begin
         if (hdr_ff) begin
            hdr_in = 1'b0;
         end else begin
            body_in = body_ff << 8;
            cnt_in = cnt_ff - 1'b1;
         end
         if (cur_last) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         hdr_in = 1'b1;
         head_in = rd_job.head;
         body_in = rd_job.body;
         cnt_in = rd_job.nbody;
      end

      rsp_valid_in = load_out ? busy_ff : rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_data_in.out_byte = cur_byte;
         rsp_data_in.last_byte = cur_last;
      end
      rsp_valid = rsp_valid_ff;
      rsp_data = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      body_ff <= body_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         hdr_ff <= 1'b0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         hdr_ff <= hdr_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_body_left: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !hdr_ff) |-> (cnt_ff != '0 && cnt_ff <= NBYTE_W'(WORD_BYTES)))
      else $error("body phase without bytes left");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> (busy_ff && hdr_ff))
      else $error("popped job not started with header");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      (pop && busy_ff) |-> (load_out && cur_last))
      else $error("pop while a run is still open");

endmodule
